// ===== design/assert_macros.svh =====
// assertion macros shared by the descrambler rtl
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== design/gslld_pkg.sv =====
// types and constants of the gold sequence llr descrambler
// no dependencies
package gslld_pkg;

  localparam int unsigned LLR_BITS_DEF = 16;
  localparam int unsigned LLR_W        = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CELL_W       = 10;
  localparam int unsigned SEQ_W        = 31;
  localparam int unsigned SHIFT_W      = 3;
  localparam int unsigned SPAN_W       = 10;
  localparam int unsigned SKIP_W       = SHIFT_W + SPAN_W;
  localparam int unsigned CNT_W        = 14;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CNT_W-1:0]  WARMUP_STEPS = CNT_W'(1600);
  localparam logic [WORD_W-1:0] BYPASS_RESET = 32'h0100_0041;
  localparam logic [SEQ_W-1:0]  X1_SEED      = SEQ_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS  = 2'd1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_LLR   = 2'd1,
    FUNC_WORD  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_WORD,
    ST_WDONE
  } state_e;

  typedef struct packed {
    logic gen_load;
    logic skip_step;
    logic llr_fire;
    logic word_load;
    logic word_step;
    logic word_done;
  } ctl_t;

  typedef struct packed {
    logic load;
    logic adv;
  } gen_cmd_t;

endpackage

// ===== design/gslld_if.sv =====
// handshake channels of the descrambler: input items, results, config writes
// depends on gslld_pkg
interface gslld_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [gslld_pkg::SHIFT_W-1:0]       shift_index;
  logic [gslld_pkg::SPAN_W-1:0]        span_length;
  logic signed [gslld_pkg::LLR_W-1:0]  llr_in;
  logic [gslld_pkg::WORD_W-1:0]        payload_word;

  modport source (output valid, func, shift_index, span_length, llr_in, payload_word,
                  input ready);
  modport sink (input valid, func, shift_index, span_length, llr_in, payload_word,
                output ready);
endinterface

interface gslld_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gslld_pkg::LLR_W-1:0]  llr_out;
  logic [gslld_pkg::WORD_W-1:0]        word_out;

  modport source (output valid, llr_out, word_out, input ready);
  modport sink (input valid, llr_out, word_out, output ready);
endinterface

interface gslld_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gslld_pkg::CFG_IDX_W-1:0]     index;
  logic [gslld_pkg::WORD_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/gslld_gen.sv =====
// gold sequence generator: the two 31-bit lfsrs, one step per cycle while advanced
// depends on gslld_pkg
module gslld_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gslld_pkg::gen_cmd_t            cmd_i,
  input  logic [gslld_pkg::SEQ_W-1:0]    seed_i,
  output logic                           c_o
);

  logic [gslld_pkg::SEQ_W-1:0] x1_q, x1_d;
  logic [gslld_pkg::SEQ_W-1:0] x2_q, x2_d;
  logic                        f1, f2;

  assign f1  = x1_q[0] ^ x1_q[3];
  assign f2  = x2_q[0] ^ x2_q[1] ^ x2_q[2] ^ x2_q[3];
  assign c_o = x1_q[0] ^ x2_q[0];

  always_comb begin
    x1_d = x1_q;
    x2_d = x2_q;
    if (cmd_i.load) begin
      x1_d = gslld_pkg::X1_SEED;
      x2_d = seed_i;
    end else if (cmd_i.adv) begin
      x1_d = {f1, x1_q[gslld_pkg::SEQ_W-1:1]};
      x2_d = {f2, x2_q[gslld_pkg::SEQ_W-1:1]};
    end
  end

  // reset seeds the cell 0 generator, the warm-up runs right after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= gslld_pkg::X1_SEED;
      x2_q <= '0;
    end else begin
      x1_q <= x1_d;
      x2_q <= x2_d;
    end
  end

endmodule

// ===== design/gslld_fsm.sv =====
// sequencer: warm-up and skip count, payload bit walk, item acceptance
// depends on gslld_pkg and assert_macros.svh
`include "assert_macros.svh"

module gslld_fsm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [1:0]                     func_i,
  input  logic [gslld_pkg::SKIP_W-1:0]   skip_i,
  input  logic                           out_free_i,
  output logic                           in_ready_o,
  output gslld_pkg::ctl_t                ctl_o,
  output logic [gslld_pkg::IDX_W-1:0]    idx_o
);

  gslld_pkg::state_e             state_q, state_d;
  logic [gslld_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [gslld_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                          accept;
  logic                          word_last;

  assign in_ready_o = (state_q == gslld_pkg::ST_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign idx_o      = idx_q;
  assign word_last  = (state_q == gslld_pkg::ST_WORD) && (idx_q == '1);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    case (state_q)
      gslld_pkg::ST_IDLE: begin
        if (in_valid_i && out_free_i) begin
          case (gslld_pkg::func_e'(func_i))
            gslld_pkg::FUNC_START: begin
              state_d = gslld_pkg::ST_SKIP;
              cnt_d   = gslld_pkg::WARMUP_STEPS + gslld_pkg::CNT_W'(skip_i);
            end
            gslld_pkg::FUNC_WORD: begin
              state_d = gslld_pkg::ST_WORD;
              idx_d   = '0;
            end
            default: ;
          endcase
        end
      end
      gslld_pkg::ST_SKIP: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == gslld_pkg::CNT_W'(1)) begin
          state_d = gslld_pkg::ST_IDLE;
        end
      end
      gslld_pkg::ST_WORD: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == '1) begin
          state_d = gslld_pkg::ST_WDONE;
        end
      end
      gslld_pkg::ST_WDONE: begin
        if (out_free_i) begin
          state_d = gslld_pkg::ST_IDLE;
        end
      end
      default: state_d = gslld_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    case (state_q)
      gslld_pkg::ST_IDLE: begin
        ctl_o.gen_load  = accept && (func_i == gslld_pkg::FUNC_START);
        ctl_o.llr_fire  = accept && (func_i == gslld_pkg::FUNC_LLR);
        ctl_o.word_load = accept && (func_i == gslld_pkg::FUNC_WORD);
      end
      gslld_pkg::ST_SKIP:  ctl_o.skip_step = 1'b1;
      gslld_pkg::ST_WORD:  ctl_o.word_step = 1'b1;
      gslld_pkg::ST_WDONE: ctl_o.word_done = out_free_i;
      default: ;
    endcase
  end

  // reset enters the cell 0 warm-up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gslld_pkg::ST_SKIP;
      cnt_q   <= gslld_pkg::WARMUP_STEPS;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  `ASSERT_CLKD(a_skip_cnt_live, clk_i, rst_ni, (state_q == gslld_pkg::ST_SKIP) |-> (cnt_q != '0))
  `ASSERT_CLKD(a_load_to_skip, clk_i, rst_ni, ctl_o.gen_load |=> (state_q == gslld_pkg::ST_SKIP))
  `ASSERT_CLKD(a_word_walk_end, clk_i, rst_ni, word_last |=> (state_q == gslld_pkg::ST_WDONE))

endmodule

// ===== design/gold_sequence_llr_descrambler_core.sv =====
// gold sequence llr descrambler: llr item registered into the result register when taken, one llr per cycle
// while the result register is free; payload word: one generator step per non-bypassed bit, then result load;
// start item reseeds the single-step lfsr unit and steps it through warm-up plus shift_index*span_length.
// after reset a warm-up for cell 0 runs; no item is taken until it ends,
// config writes are taken at any time. async active-low reset clears control and sets config to its reset values.
`include "assert_macros.svh"

module gold_sequence_llr_descrambler_core #(
  parameter int unsigned LLR_BITS = gslld_pkg::LLR_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gslld_in_if.sink    in_i,
  gslld_out_if.source out_o,
  gslld_cfg_if.sink   cfg_i
);

  // saturation bounds inside the llr width
  localparam logic signed [LLR_BITS-1:0] LlrMin = {1'b1, {(LLR_BITS-1){1'b0}}};
  localparam logic signed [LLR_BITS-1:0] LlrMax = ~LlrMin;

  // configuration registers
  logic [gslld_pkg::CELL_W-1:0] cell_id_q;
  logic [gslld_pkg::WORD_W-1:0] bypass_q;

  // sequencer and generator
  gslld_pkg::ctl_t              ctl;
  gslld_pkg::gen_cmd_t          gen_cmd;
  logic [gslld_pkg::IDX_W-1:0]  idx;
  logic                         c_bit;
  logic                         out_free;
  logic [gslld_pkg::SKIP_W-1:0] skip;
  logic                         byp_bit;

  // payload walk and result register
  logic [gslld_pkg::WORD_W-1:0]       word_q;
  logic                               out_valid_q;
  logic signed [gslld_pkg::LLR_W-1:0] llr_out_q;
  logic [gslld_pkg::WORD_W-1:0]       word_out_q;

  // llr datapath
  logic signed [LLR_BITS-1:0] llr_v;
  logic signed [LLR_BITS-1:0] llr_neg;
  logic signed [LLR_BITS-1:0] llr_res;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_id_q <= '0;
      bypass_q  <= gslld_pkg::BYPASS_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gslld_pkg::CFG_CELL_ID: cell_id_q <= cfg_i.data[gslld_pkg::CELL_W-1:0];
        gslld_pkg::CFG_BYPASS:  bypass_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;
  // skip length in sequence positions, at most 7 * 1023
  assign skip     = gslld_pkg::SHIFT_W'(in_i.shift_index) * gslld_pkg::SKIP_W'(in_i.span_length);

  gslld_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .skip_i     (skip),
    .out_free_i (out_free),
    .in_ready_o (in_i.ready),
    .ctl_o      (ctl),
    .idx_o      (idx)
  );

  // bypassed payload bits consume no sequence bit
  assign byp_bit      = bypass_q[idx];
  assign gen_cmd.load = ctl.gen_load;
  assign gen_cmd.adv  = ctl.skip_step || ctl.llr_fire || (ctl.word_step && !byp_bit);

  gslld_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (gen_cmd),
    .seed_i (gslld_pkg::SEQ_W'(cell_id_q)),
    .c_o    (c_bit)
  );

  // soft value: low LLR_BITS bits, negated with saturation when the sequence bit is set
  assign llr_v   = in_i.llr_in[LLR_BITS-1:0];
  assign llr_neg = (llr_v == LlrMin) ? LlrMax : -llr_v;
  assign llr_res = c_bit ? llr_neg : llr_v;

  // payload word shifts right, descrambled bit enters at the top; in place once all 32 bits have passed
  always_ff @(posedge clk_i) begin
    if (ctl.word_load) begin
      word_q <= in_i.payload_word;
    end else if (ctl.word_step) begin
      word_q <= {word_q[0] ^ (c_bit && !byp_bit), word_q[gslld_pkg::WORD_W-1:1]};
    end
  end

  // result register, decouples the sink from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.llr_fire || ctl.word_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.llr_fire) begin
      llr_out_q  <= gslld_pkg::LLR_W'(llr_res);
      word_out_q <= '0;
    end else if (ctl.word_done) begin
      llr_out_q  <= '0;
      word_out_q <= word_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.llr_out  = llr_out_q;
  assign out_o.word_out = word_out_q;

  `ASSERT_NEVER(a_no_llr_overwrite, clk_i, rst_ni, ctl.llr_fire && out_valid_q && !out_o.ready)
  `ASSERT_NEVER(a_no_word_overwrite, clk_i, rst_ni, ctl.word_done && out_valid_q && !out_o.ready)
  `ASSERT_CLKD(a_llr_result_up, clk_i, rst_ni, ctl.llr_fire |=> out_valid_q)

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the gold sequence llr descrambler core
// depends on gslld_pkg, the gslld channel interfaces and gold_sequence_llr_descrambler_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LLR_BITS = gslld_pkg::LLR_BITS_DEF;

  // func code the block drops without a result
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [gslld_pkg::CFG_IDX_W-1:0] CFG_NONE_A = 2'd2;
  localparam logic [gslld_pkg::CFG_IDX_W-1:0] CFG_NONE_B = 2'd3;

  // longest start item: warm-up plus the largest skip, with margin
  localparam int unsigned START_DRAIN = 1601 + 7 * 1023 + 200;
  // leave room for stray results at the end
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 160;

  typedef struct {
    logic [1:0]                    func;
    logic [gslld_pkg::SHIFT_W-1:0] shift;
    logic [gslld_pkg::SPAN_W-1:0]  span;
    logic [gslld_pkg::LLR_W-1:0]   llr;
    logic [gslld_pkg::WORD_W-1:0]  word;
  } item_t;

  typedef struct {
    logic [gslld_pkg::LLR_W-1:0]  llr;
    logic [gslld_pkg::WORD_W-1:0] word;
  } result_t;

  logic clk_i;
  logic rst_ni;

  gslld_in_if  in_if ();
  gslld_out_if out_if ();
  gslld_cfg_if cfg_if ();

  gold_sequence_llr_descrambler_core #(
    .LLR_BITS(LLR_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // items waiting to be driven, and descrambled results not yet seen
  item_t   item_backlog[$];
  result_t due_results[$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  // chance in percent that either side starts an idle burst
  int unsigned idle_pct   = 0;
  int unsigned src_gap    = 0;
  int unsigned sink_gap   = 0;

  // ---------------------------------------------------------------------------
  // gold sequence predictor: own copy of both shift windows and of the registers
  // ---------------------------------------------------------------------------
  logic [gslld_pkg::SEQ_W-1:0]  x1_win;
  logic [gslld_pkg::SEQ_W-1:0]  x2_win;
  logic [gslld_pkg::CELL_W-1:0] cell_copy;
  logic [gslld_pkg::WORD_W-1:0] bypass_copy;

  // one step of both lfsrs, bit 0 is the current element
  function automatic void gold_advance();
    logic fb1;
    logic fb2;
    fb1    = x1_win[0] ^ x1_win[3];
    fb2    = x2_win[0] ^ x2_win[1] ^ x2_win[2] ^ x2_win[3];
    x1_win = {fb1, x1_win[gslld_pkg::SEQ_W-1:1]};
    x2_win = {fb2, x2_win[gslld_pkg::SEQ_W-1:1]};
  endfunction

  function automatic logic gold_bit();
    logic c;
    c = x1_win[0] ^ x2_win[0];
    gold_advance();
    return c;
  endfunction

  // reseed from the cell id, run the warm-up, then skip ahead
  function automatic void gold_restart(int unsigned skip);
    x1_win = gslld_pkg::X1_SEED;
    x2_win = gslld_pkg::SEQ_W'(cell_copy);
    repeat (skip + gslld_pkg::WARMUP_STEPS) gold_advance();
  endfunction

  // returns 1 when the item yields a result
  function automatic bit descramble(input item_t it, output result_t res);
    logic signed [LLR_BITS-1:0] llr_val;
    logic signed [LLR_BITS-1:0] most_neg;
    res.llr  = '0;
    res.word = '0;
    most_neg = {1'b1, {(LLR_BITS-1){1'b0}}};
    case (it.func)
      gslld_pkg::FUNC_START: begin
        gold_restart(int'(it.shift) * int'(it.span));
        return 1'b0;
      end
      gslld_pkg::FUNC_LLR: begin
        llr_val = it.llr[LLR_BITS-1:0];
        // negation of the most negative value saturates
        if (gold_bit()) llr_val = (llr_val == most_neg) ? ~most_neg : -llr_val;
        res.llr = gslld_pkg::LLR_W'(llr_val);
        return 1'b1;
      end
      gslld_pkg::FUNC_WORD: begin
        // bypassed bits pass as they are and use no sequence bit
        for (int i = 0; i < gslld_pkg::WORD_W; i++) begin
          res.word[i] = it.word[i];
          if (!bypass_copy[i]) res.word[i] = it.word[i] ^ gold_bit();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------

  // every accepted item runs through the predictor at the edge it is taken
  always @(posedge clk_i) begin
    item_t   seen;
    result_t want;
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen.func  = in_if.func;
      seen.shift = in_if.shift_index;
      seen.span  = in_if.span_length;
      seen.llr   = in_if.llr_in;
      seen.word  = in_if.payload_word;
      if (descramble(seen, want)) due_results.push_back(want);
    end
  end

  // register writes update the predictor copies; cell id only counts at the next start
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        gslld_pkg::CFG_CELL_ID: cell_copy = cfg_if.data[gslld_pkg::CELL_W-1:0];
        gslld_pkg::CFG_BYPASS:  bypass_copy = cfg_if.data;
        default: ;
      endcase
    end
  end

  // results are checked in order against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: llr %0d word %h", $signed(out_if.llr_out),
                   out_if.word_out);
      end else begin
        want = due_results.pop_front();
        if (out_if.llr_out !== want.llr) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("llr mismatch: expected %0d, got %0d", $signed(want.llr),
                     $signed(out_if.llr_out));
        end
        if (out_if.word_out !== want.word) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("word mismatch: expected %h, got %h", want.word, out_if.word_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // item driver: holds an item until taken, starts idle bursts at random
  always @(posedge clk_i) begin
    item_t nxt;
    if (rst_ni && !(in_if.valid && !in_if.ready)) begin
      if (src_gap != 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (item_backlog.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        src_gap = $urandom_range(3);
        in_if.valid <= 1'b0;
      end else begin
        nxt = item_backlog.pop_front();
        in_if.valid        <= 1'b1;
        in_if.func         <= nxt.func;
        in_if.shift_index  <= nxt.shift;
        in_if.span_length  <= nxt.span;
        in_if.llr_in       <= nxt.llr;
        in_if.payload_word <= nxt.word;
      end
    end
  end

  // result sink: stalls in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap != 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        sink_gap = $urandom_range(3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic item_t make_item(logic [1:0] func, logic [gslld_pkg::SHIFT_W-1:0] shift,
                                      logic [gslld_pkg::SPAN_W-1:0] span,
                                      logic [gslld_pkg::LLR_W-1:0] llr,
                                      logic [gslld_pkg::WORD_W-1:0] word);
    item_t it;
    it.func  = func;
    it.shift = shift;
    it.span  = span;
    it.llr   = llr;
    it.word  = word;
    return it;
  endfunction

  // mostly llr and word streams, some restarts, a little noise
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    it = make_item(gslld_pkg::FUNC_LLR, gslld_pkg::SHIFT_W'($urandom()),
                   gslld_pkg::SPAN_W'($urandom()), gslld_pkg::LLR_W'($urandom()),
                   $urandom());
    pick = $urandom_range(99);
    if (pick < 4) begin
      it.func = gslld_pkg::FUNC_START;
      // keep most skips short, a few use the whole range
      if ($urandom_range(7) != 0) begin
        it.shift = gslld_pkg::SHIFT_W'($urandom_range(1));
        it.span  = gslld_pkg::SPAN_W'($urandom_range(255));
      end
    end else if (pick < 6) begin
      it.func = FUNC_SPARE;
    end else if (pick < 40) begin
      it.func = gslld_pkg::FUNC_WORD;
    end else if (pick < 48) begin
      case ($urandom_range(4))
        0: it.llr = 16'h8000;
        1: it.llr = 16'h7fff;
        2: it.llr = 16'h0000;
        3: it.llr = 16'hffff;
        default: it.llr = 16'h0001;
      endcase
    end
    return it;
  endfunction

  // waits until every item is taken and every result has come back
  task automatic wait_results_done();
    while (item_backlog.size() != 0 || in_if.valid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // one register write, called at a clock edge, returns at the accepting edge
  task automatic cfg_write(logic [gslld_pkg::CFG_IDX_W-1:0] idx,
                           logic [gslld_pkg::WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  initial begin
    logic [gslld_pkg::CELL_W-1:0] cell_val;
    logic [gslld_pkg::WORD_W-1:0] mask_val;
    int unsigned                  counted;
    item_t                        it;
    int unsigned                  phase_idle[PHASES] = '{30, 15, 0, 40, 25, 0};

    // every driven input known from time zero
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.func          = gslld_pkg::FUNC_START;
    in_if.shift_index   = '0;
    in_if.span_length   = '0;
    in_if.llr_in        = '0;
    in_if.payload_word  = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = gslld_pkg::CFG_CELL_ID;
    cfg_if.data         = '0;

    // predictor state after reset: cell 0, warm-up done, reset bypass mask
    cell_copy   = '0;
    bypass_copy = gslld_pkg::BYPASS_RESET;
    gold_restart(0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset settings
    idle_pct = 20;
    // items before any start use the cell 0 sequence right after the warm-up
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h1234, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, 32'hffff_ffff));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 0, 0, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h8000, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h7fff, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h0000, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'hffff, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, 32'h0000_0000));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, 32'hffff_ffff));
    // unused code: no result, sequence untouched
    item_backlog.push_back(make_item(FUNC_SPARE, 7, 1023, 16'hffff, 32'hffff_ffff));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h0001, 0));
    // largest skip
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 7, 1023, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h8000, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, 32'ha5a5_5a5a));
    // zero multiplier with full span, then full multiplier with zero span
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 0, 1023, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h8000, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 7, 0, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, 32'h5a5a_a5a5));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 5, 10'h2aa, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0, 16'h7fff, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_START, 2, 10'h155, 0, 0));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_WORD, 0, 0, 0, $urandom()));
    item_backlog.push_back(make_item(gslld_pkg::FUNC_LLR, 0, 0,
                                     gslld_pkg::LLR_W'($urandom()), 0));
    wait_results_done();

    for (int p = 0; p < PHASES; p++) begin
      // a start may still be running with nothing left to return
      repeat (START_DRAIN) @(posedge clk_i);

      case (p)
        0: begin
          cell_val = 10'd1007;
          mask_val = 32'h0000_0000;
        end
        1: begin
          cell_val = 10'd0;
          mask_val = 32'hffff_ffff;
        end
        3: begin
          cell_val = 10'd1007;
          mask_val = gslld_pkg::BYPASS_RESET;
        end
        default: begin
          cell_val = gslld_pkg::CELL_W'($urandom_range(1007));
          mask_val = $urandom();
        end
      endcase

      if (p == 2) begin
        // writes past the register map must leave everything alone
        cfg_write(CFG_NONE_A, $urandom());
        cfg_write(CFG_NONE_B, $urandom());
      end
      cfg_write(gslld_pkg::CFG_CELL_ID, gslld_pkg::WORD_W'(cell_val));
      cfg_write(gslld_pkg::CFG_BYPASS, mask_val);
      cfg_if.valid <= 1'b0;

      idle_pct = phase_idle[p];
      counted  = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        item_backlog.push_back(it);
        if (it.func != FUNC_SPARE) counted++;
        // in phase 3, at the halfway point, hold the sender until the block has caught up
        if (p == 3 && counted == PHASE_ITEMS / 2 && it.func != FUNC_SPARE)
          wait_results_done();
      end
      wait_results_done();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
